// ===== sv/keyword_lexer_tokenizer_unit_macros.svh =====
// assertion macros for the keyword lexer tokenizer
`ifndef KEYWORD_LEXER_TOKENIZER_UNIT_MACROS_SVH
`define KEYWORD_LEXER_TOKENIZER_UNIT_MACROS_SVH

// same-cycle implication, checked out of reset
`define KLT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define KLT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/klt_pkg.sv =====
// shared types, token codes and keyword table for the keyword lexer tokenizer
`default_nettype none

package klt_pkg;

  localparam int MAX_IDENT_CHARS = 8;
  localparam int TEXT_W          = 8 * MAX_IDENT_CHARS;
  localparam int CNT_W           = 4;
  localparam int NUM_W           = 31;
  localparam int CODE_W          = 6;
  localparam int OUT_TEXT_W      = 64;
  localparam int OUT_TDATA_W     = 112;
  localparam int Q_DEPTH         = 4;
  localparam int Q_AW            = 2;
  localparam int KW_COUNT        = 17;
  localparam int KW_CHARS        = 5;

  localparam logic [NUM_W-1:0] NUM_MAX = {NUM_W{1'b1}};

  localparam logic [CODE_W-1:0] TOK_IDENT    = 6'd0;
  localparam logic [CODE_W-1:0] TOK_NUMBER   = 6'd1;
  localparam logic [CODE_W-1:0] TOK_KW_BASE  = 6'd2;
  localparam logic [CODE_W-1:0] TOK_LPAREN   = 6'd19;
  localparam logic [CODE_W-1:0] TOK_RPAREN   = 6'd20;
  localparam logic [CODE_W-1:0] TOK_COMMA    = 6'd21;
  localparam logic [CODE_W-1:0] TOK_PERIOD   = 6'd22;
  localparam logic [CODE_W-1:0] TOK_SEMI     = 6'd23;
  localparam logic [CODE_W-1:0] TOK_ASSIGN   = 6'd24;
  localparam logic [CODE_W-1:0] TOK_PLUS     = 6'd25;
  localparam logic [CODE_W-1:0] TOK_MINUS    = 6'd26;
  localparam logic [CODE_W-1:0] TOK_STAR     = 6'd27;
  localparam logic [CODE_W-1:0] TOK_SLASH    = 6'd28;
  localparam logic [CODE_W-1:0] TOK_BAR      = 6'd29;
  localparam logic [CODE_W-1:0] TOK_EQUAL    = 6'd30;
  localparam logic [CODE_W-1:0] TOK_NOTEQ    = 6'd31;
  localparam logic [CODE_W-1:0] TOK_LESS     = 6'd32;
  localparam logic [CODE_W-1:0] TOK_LESSEQ   = 6'd33;
  localparam logic [CODE_W-1:0] TOK_GREATER  = 6'd34;
  localparam logic [CODE_W-1:0] TOK_GREATEQ  = 6'd35;
  localparam logic [CODE_W-1:0] TOK_ERROR    = 6'd36;

  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_PERIOD  = 8'h2E;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_SEMI    = 8'h3B;
  localparam logic [7:0] CH_LESS    = 8'h3C;
  localparam logic [7:0] CH_EQUAL   = 8'h3D;
  localparam logic [7:0] CH_GREATER = 8'h3E;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] CH_LBRACE  = 8'h7B;
  localparam logic [7:0] CH_BAR     = 8'h7C;
  localparam logic [7:0] CH_RBRACE  = 8'h7D;
  localparam logic [7:0] CASE_GAP   = 8'h20;

  // first character in the high byte, padded with zeros
  localparam logic [8*KW_CHARS-1:0] KW_NAME [KW_COUNT] = '{
    "BEGIN", {"END", 16'h0}, {"INT", 16'h0}, {"VAR", 16'h0}, {"PROC", 8'h0},
    {"CALL", 8'h0}, {"READ", 8'h0}, "WRITE", {"IF", 24'h0}, {"THEN", 8'h0},
    {"ELSE", 8'h0}, {"FI", 24'h0}, "WHILE", {"DO", 24'h0}, {"OD", 24'h0},
    {"NEG", 16'h0}, {"ABS", 16'h0}
  };
  localparam logic [CNT_W-1:0] KW_LEN [KW_COUNT] = '{
    4'd5, 4'd3, 4'd3, 4'd3, 4'd4, 4'd4, 4'd4, 4'd5, 4'd2, 4'd4,
    4'd4, 4'd2, 4'd5, 4'd2, 4'd2, 4'd3, 4'd3
  };

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_IDENT   = 3'd1,
    MODE_NUMBER  = 3'd2,
    MODE_COMMENT = 3'd3,
    MODE_COLON   = 3'd4,
    MODE_LESS    = 3'd5,
    MODE_GREATER = 3'd6,
    MODE_DONE    = 3'd7
  } mode_t;

  // one input item's results: a full first token and an optional plain second one
  typedef struct packed {
    logic [CODE_W-1:0]     code0;
    logic [NUM_W-1:0]      value;
    logic [OUT_TEXT_W-1:0] text;
    logic [CNT_W-1:0]      len;
    logic                  ovf;
    logic                  two;
    logic [CODE_W-1:0]     code1;
  } tok_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [CODE_W-1:0] kw_lookup(input logic [TEXT_W-1:0] text,
                                                  input logic [CNT_W-1:0]  len,
                                                  input logic              trunc);
    logic [8*KW_CHARS-1:0] key;
    logic [7:0]            ch;
    logic [CODE_W-1:0]     code;
    key  = '0;
    code = TOK_IDENT;
    for (int i = 0; i < KW_CHARS; i++) begin
      ch = text[8*i +: 8];
      if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z) begin
        ch = ch - CASE_GAP;
      end
      key[8*(KW_CHARS-1-i) +: 8] = ch;
    end
    for (int k = 0; k < KW_COUNT; k++) begin
      if (!trunc && code == TOK_IDENT && len == KW_LEN[k] && key == KW_NAME[k]) begin
        code = TOK_KW_BASE + CODE_W'(k);
      end
    end
    return code;
  endfunction

endpackage

`default_nettype wire

// ===== sv/keyword_lexer_tokenizer_unit.sv =====
// top level of the keyword lexer tokenizer: scanner, token queue and output stage
// the first token of a byte is written into the queue when the byte is taken, then loaded into the output register
// throughput: one byte per cycle while the queue is not full; a byte that closes a token and is
//   itself a one-character token yields two tokens from one queue entry, buffered by a four-entry queue
// reset: synchronous, active low; scanner returns to idle, queue and output empty
`default_nettype none

module keyword_lexer_tokenizer_unit (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output      logic                                in_tready,
  input  wire logic [7:0]                          in_tdata,   // char_code
  input  wire logic                                in_tlast,   // end_of_text
  output      logic                                out_tvalid,
  input  wire logic                                out_tready,
  // token_code, number_value, ident_text, ident_length, overflow_flag, zero pad
  output      logic [klt_pkg::OUT_TDATA_W-1:0]     out_tdata,
  output      logic                                out_tlast   // last_of_run
);

  logic                wr_en, rd_en;
  klt_pkg::tok_entry_t wr_entry, q_head;
  klt_pkg::q_stat_t    q_stat;

  klt_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_stat    (q_stat),
    .wr_en     (wr_en),
    .wr_entry  (wr_entry)
  );

  klt_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (wr_en),
    .wr_entry (wr_entry),
    .rd_en    (rd_en),
    .rd_entry (q_head),
    .stat     (q_stat)
  );

  klt_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_head     (q_head),
    .q_stat     (q_stat),
    .rd_en      (rd_en),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

// ===== sv/klt_front.sv =====
// scanner front end: takes one byte per cycle while the queue is not full and classifies it into tokens
`default_nettype none
`include "keyword_lexer_tokenizer_unit_macros.svh"

module klt_front (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_tvalid,
  output      logic                in_tready,
  input  wire logic [7:0]          in_tdata,  // char_code
  input  wire logic                in_tlast,  // end_of_text
  input  wire klt_pkg::q_stat_t    q_stat,
  output      logic                wr_en,
  output      klt_pkg::tok_entry_t wr_entry
);

  klt_pkg::mode_t                  mode_r, mode_nxt, idle_mode;
  logic [klt_pkg::TEXT_W-1:0]      text_r, text_nxt;
  logic [klt_pkg::CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                            trunc_r, trunc_nxt;
  logic [klt_pkg::NUM_W-1:0]       acc_r, acc_nxt;
  logic                            sat_r, sat_nxt;

  logic                            fire, run_idle, e0;
  logic [7:0]                      c;
  logic                            is_let, is_dig;
  logic [3:0]                      digit;
  logic                            idle_emit;
  logic [klt_pkg::CODE_W-1:0]      idle_code, kw;
  logic [klt_pkg::NUM_W+3:0]       acc_x, acc_mul;
  klt_pkg::tok_entry_t             ent;

  assign in_tready = !q_stat.full;
  assign fire      = in_tvalid && in_tready;
  assign kw        = klt_pkg::kw_lookup(text_r, cnt_r, trunc_r);

  // single-byte classification from idle
  always_comb begin
    c         = in_tdata;
    is_let    = (c >= klt_pkg::CH_UPPER_A && c <= klt_pkg::CH_UPPER_Z) ||
                (c >= klt_pkg::CH_LOWER_A && c <= klt_pkg::CH_LOWER_Z);
    is_dig    = c >= klt_pkg::CH_ZERO && c <= klt_pkg::CH_NINE;
    digit     = 4'(c - klt_pkg::CH_ZERO);
    idle_emit = 1'b0;
    idle_code = klt_pkg::TOK_ERROR;
    idle_mode = klt_pkg::MODE_IDLE;
    if (c > klt_pkg::CH_SPACE && !c[7]) begin
      if (is_let) begin
        idle_mode = klt_pkg::MODE_IDENT;
      end else if (is_dig) begin
        idle_mode = klt_pkg::MODE_NUMBER;
      end else begin
        idle_emit = 1'b1;
        unique case (c)
          klt_pkg::CH_LBRACE: begin
            idle_emit = 1'b0;
            idle_mode = klt_pkg::MODE_COMMENT;
          end
          klt_pkg::CH_COLON: begin
            idle_emit = 1'b0;
            idle_mode = klt_pkg::MODE_COLON;
          end
          klt_pkg::CH_LESS: begin
            idle_emit = 1'b0;
            idle_mode = klt_pkg::MODE_LESS;
          end
          klt_pkg::CH_GREATER: begin
            idle_emit = 1'b0;
            idle_mode = klt_pkg::MODE_GREATER;
          end
          klt_pkg::CH_LPAREN:  idle_code = klt_pkg::TOK_LPAREN;
          klt_pkg::CH_RPAREN:  idle_code = klt_pkg::TOK_RPAREN;
          klt_pkg::CH_COMMA:   idle_code = klt_pkg::TOK_COMMA;
          klt_pkg::CH_PERIOD: begin
            idle_code = klt_pkg::TOK_PERIOD;
            idle_mode = klt_pkg::MODE_DONE;
          end
          klt_pkg::CH_SEMI:    idle_code = klt_pkg::TOK_SEMI;
          klt_pkg::CH_PLUS:    idle_code = klt_pkg::TOK_PLUS;
          klt_pkg::CH_MINUS:   idle_code = klt_pkg::TOK_MINUS;
          klt_pkg::CH_STAR:    idle_code = klt_pkg::TOK_STAR;
          klt_pkg::CH_SLASH:   idle_code = klt_pkg::TOK_SLASH;
          klt_pkg::CH_BAR:     idle_code = klt_pkg::TOK_BAR;
          klt_pkg::CH_EQUAL:   idle_code = klt_pkg::TOK_EQUAL;
          default:             idle_code = klt_pkg::TOK_ERROR;
        endcase
      end
    end
  end

  // decimal accumulate: acc * 10 + digit
  always_comb begin
    acc_x   = (klt_pkg::NUM_W+4)'(acc_r);
    acc_mul = (acc_x << 3) + (acc_x << 1) + (klt_pkg::NUM_W+4)'(digit);
  end

  always_comb begin
    mode_nxt  = mode_r;
    text_nxt  = text_r;
    cnt_nxt   = cnt_r;
    trunc_nxt = trunc_r;
    acc_nxt   = acc_r;
    sat_nxt   = sat_r;
    e0        = 1'b0;
    run_idle  = 1'b0;
    ent       = '0;
    if (fire) begin
      if (in_tlast) begin
        unique case (mode_r)
          klt_pkg::MODE_IDENT: begin
            e0        = 1'b1;
            ent.code0 = kw;
            ent.text  = klt_pkg::OUT_TEXT_W'(text_r);
            ent.len   = cnt_r;
            ent.ovf   = trunc_r;
          end
          klt_pkg::MODE_NUMBER: begin
            e0        = 1'b1;
            ent.code0 = klt_pkg::TOK_NUMBER;
            ent.value = acc_r;
            ent.ovf   = sat_r;
          end
          klt_pkg::MODE_COLON: begin
            e0        = 1'b1;
            ent.code0 = klt_pkg::TOK_ERROR;
          end
          klt_pkg::MODE_LESS: begin
            e0        = 1'b1;
            ent.code0 = klt_pkg::TOK_LESS;
          end
          klt_pkg::MODE_GREATER: begin
            e0        = 1'b1;
            ent.code0 = klt_pkg::TOK_GREATER;
          end
          default: begin
            e0 = 1'b0;
          end
        endcase
        mode_nxt  = klt_pkg::MODE_IDLE;
        cnt_nxt   = '0;
        trunc_nxt = 1'b0;
        acc_nxt   = '0;
        sat_nxt   = 1'b0;
      end else begin
        unique case (mode_r)
          klt_pkg::MODE_DONE: begin
            mode_nxt = klt_pkg::MODE_DONE;
          end
          klt_pkg::MODE_COMMENT: begin
            if (c == klt_pkg::CH_RBRACE) begin
              mode_nxt = klt_pkg::MODE_IDLE;
            end
          end
          klt_pkg::MODE_IDENT: begin
            if (is_let || is_dig) begin
              if (cnt_r < klt_pkg::CNT_W'(klt_pkg::MAX_IDENT_CHARS)) begin
                for (int i = 0; i < klt_pkg::MAX_IDENT_CHARS; i++) begin
                  if (cnt_r == klt_pkg::CNT_W'(i)) begin
                    text_nxt[8*i +: 8] = c;
                  end
                end
                cnt_nxt = cnt_r + 1'b1;
              end else begin
                trunc_nxt = 1'b1;
              end
            end else begin
              e0        = 1'b1;
              ent.code0 = kw;
              ent.text  = klt_pkg::OUT_TEXT_W'(text_r);
              ent.len   = cnt_r;
              ent.ovf   = trunc_r;
              run_idle  = 1'b1;
            end
          end
          klt_pkg::MODE_NUMBER: begin
            if (is_dig) begin
              if (acc_mul > (klt_pkg::NUM_W+4)'(klt_pkg::NUM_MAX)) begin
                acc_nxt = klt_pkg::NUM_MAX;
                sat_nxt = 1'b1;
              end else begin
                acc_nxt = acc_mul[klt_pkg::NUM_W-1:0];
              end
            end else begin
              e0        = 1'b1;
              ent.code0 = klt_pkg::TOK_NUMBER;
              ent.value = acc_r;
              ent.ovf   = sat_r;
              run_idle  = 1'b1;
            end
          end
          klt_pkg::MODE_COLON: begin
            e0       = 1'b1;
            mode_nxt = klt_pkg::MODE_IDLE;
            if (c == klt_pkg::CH_EQUAL) begin
              ent.code0 = klt_pkg::TOK_ASSIGN;
            end else begin
              ent.code0 = klt_pkg::TOK_ERROR;
              run_idle  = 1'b1;
            end
          end
          klt_pkg::MODE_LESS: begin
            e0       = 1'b1;
            mode_nxt = klt_pkg::MODE_IDLE;
            if (c == klt_pkg::CH_GREATER) begin
              ent.code0 = klt_pkg::TOK_NOTEQ;
            end else if (c == klt_pkg::CH_EQUAL) begin
              ent.code0 = klt_pkg::TOK_LESSEQ;
            end else begin
              ent.code0 = klt_pkg::TOK_LESS;
              run_idle  = 1'b1;
            end
          end
          klt_pkg::MODE_GREATER: begin
            e0       = 1'b1;
            mode_nxt = klt_pkg::MODE_IDLE;
            if (c == klt_pkg::CH_EQUAL) begin
              ent.code0 = klt_pkg::TOK_GREATEQ;
            end else begin
              ent.code0 = klt_pkg::TOK_GREATER;
              run_idle  = 1'b1;
            end
          end
          default: begin
            run_idle = 1'b1;
          end
        endcase
      end
      // byte classified from idle when the scanner is idle or after a token closes
      if (run_idle) begin
        mode_nxt = idle_mode;
        if (idle_emit) begin
          if (e0) begin
            ent.two   = 1'b1;
            ent.code1 = idle_code;
          end else begin
            e0        = 1'b1;
            ent.code0 = idle_code;
          end
        end
        if (idle_mode == klt_pkg::MODE_IDENT) begin
          text_nxt  = klt_pkg::TEXT_W'(c);
          cnt_nxt   = klt_pkg::CNT_W'(1);
          trunc_nxt = 1'b0;
        end
        if (idle_mode == klt_pkg::MODE_NUMBER) begin
          acc_nxt = klt_pkg::NUM_W'(digit);
          sat_nxt = 1'b0;
        end
      end
    end
  end

  assign wr_en    = e0;
  assign wr_entry = ent;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= klt_pkg::MODE_IDLE;
      cnt_r   <= '0;
      trunc_r <= 1'b0;
      acc_r   <= '0;
      sat_r   <= 1'b0;
    end else begin
      mode_r  <= mode_nxt;
      cnt_r   <= cnt_nxt;
      trunc_r <= trunc_nxt;
      acc_r   <= acc_nxt;
      sat_r   <= sat_nxt;
    end
  end

  always_ff @(posedge clk) begin
    text_r <= text_nxt;
  end

  `KLT_ASSERT_NEXT(a_done_holds, fire && !in_tlast && mode_r == klt_pkg::MODE_DONE, mode_r == klt_pkg::MODE_DONE, "scanner left done state without end marker")
  `KLT_ASSERT_SAME(a_pair_has_first, wr_en && wr_entry.two, wr_entry.code0 != klt_pkg::TOK_PERIOD, "period token followed by a second token")

endmodule

`default_nettype wire

// ===== sv/klt_queue.sv =====
// short token queue between the scanner and the output stage
`default_nettype none
`include "keyword_lexer_tokenizer_unit_macros.svh"

module klt_queue (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                wr_en,
  input  wire klt_pkg::tok_entry_t wr_entry,
  input  wire logic                rd_en,
  output      klt_pkg::tok_entry_t rd_entry,
  output      klt_pkg::q_stat_t    stat
);

  klt_pkg::tok_entry_t         mem_r [klt_pkg::Q_DEPTH];
  logic [klt_pkg::Q_AW-1:0]    wp_r, wp_nxt, rp_r, rp_nxt;
  logic [klt_pkg::Q_AW:0]      cnt_r, cnt_nxt;

  assign stat.full  = cnt_r == (klt_pkg::Q_AW+1)'(klt_pkg::Q_DEPTH);
  assign stat.empty = cnt_r == '0;
  assign rd_entry   = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wr_en ? wp_r + 1'b1 : wp_r;
    rp_nxt  = rd_en ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r;
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!wr_en && rd_en) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wp_r] <= wr_entry;
    end
  end

  `KLT_ASSERT_SAME(a_no_push_full, wr_en, !stat.full, "push into full token queue")
  `KLT_ASSERT_SAME(a_no_pop_empty, rd_en, !stat.empty, "pop from empty token queue")

endmodule

`default_nettype wire

// ===== sv/klt_back.sv =====
// output stage: drains queue to output register, one token per cycle if not stalled
`default_nettype none
`include "keyword_lexer_tokenizer_unit_macros.svh"

module klt_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire klt_pkg::tok_entry_t q_head,
  input  wire klt_pkg::q_stat_t    q_stat,
  output      logic                rd_en,
  output      logic                out_tvalid,
  input  wire logic                out_tready,
  // token_code, number_value, ident_text, ident_length, overflow_flag, zero pad
  output      logic [klt_pkg::OUT_TDATA_W-1:0] out_tdata,
  output      logic                out_tlast  // last_of_run
);

  localparam int PAD_W = klt_pkg::OUT_TDATA_W - klt_pkg::CODE_W - klt_pkg::NUM_W
                         - klt_pkg::OUT_TEXT_W - klt_pkg::CNT_W - 1;

  logic                            valid_r, valid_nxt;
  logic                            sub_r, sub_nxt;
  logic                            last_r, last_nxt;
  logic [klt_pkg::OUT_TDATA_W-1:0] data_r, data_nxt;
  logic                            load;

  assign load = !valid_r || out_tready;

  always_comb begin
    valid_nxt = valid_r;
    sub_nxt   = sub_r;
    last_nxt  = last_r;
    data_nxt  = data_r;
    rd_en     = 1'b0;
    if (load) begin
      valid_nxt = !q_stat.empty;
      if (!q_stat.empty) begin
        if (sub_r) begin
          data_nxt = {PAD_W'(0), 1'b0, klt_pkg::CNT_W'(0), klt_pkg::OUT_TEXT_W'(0),
                      klt_pkg::NUM_W'(0), q_head.code1};
          last_nxt = 1'b1;
          sub_nxt  = 1'b0;
          rd_en    = 1'b1;
        end else begin
          data_nxt = {PAD_W'(0), q_head.ovf, q_head.len, q_head.text,
                      q_head.value, q_head.code0};
          last_nxt = !q_head.two;
          sub_nxt  = q_head.two;
          rd_en    = !q_head.two;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      sub_r   <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      sub_r   <= sub_nxt;
    end
  end

  always_ff @(posedge clk) begin
    last_r <= last_nxt;
    data_r <= data_nxt;
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;
  assign out_tlast  = last_r;

  `KLT_ASSERT_SAME(a_sub_has_pair, sub_r, !q_stat.empty && q_head.two, "second token pending without a paired entry")
  `KLT_ASSERT_SAME(a_sub_not_last, sub_r && valid_r, !last_r, "first token of a pair marked last")

endmodule

`default_nettype wire
